@@ design/assert_macros.svh @@
// Assertion macros shared by the processor core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked property, switched off while reset is high
`define TFBC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");
// Clocked property that is also checked through reset
`define TFBC_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("%m: assertion failed");
`else
`define TFBC_ASSERT(label, clk, rst, prop)
`define TFBC_ASSERT_NR(label, clk, prop)
`endif
`endif

@@ design/tfbc_pkg.sv @@
// Shared types and constants of the four-bit processor core.
package tfbc_pkg;

   // Default instruction memory depth
   localparam int MEM_DEPTH_DEFAULT = 16;

   // Field widths
   localparam int WORD_W  = 8;
   localparam int ADDR_W  = 4;
   localparam int NIB_W   = 4;
   localparam int IMM_W   = 3;

   // Stream widths
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;

   // Transaction kinds carried on req_tuser
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_STEP = 1'b1;

   // Destination field of the instruction word
   typedef enum logic [1:0] {
      DEST_A    = 2'b00,
      DEST_B    = 2'b01,
      DEST_OUT  = 2'b10,
      DEST_NONE = 2'b11
   } dest_type;

   // Instruction memory write port
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [WORD_W-1:0] word;
   } mem_wr_type;

   // Result of one step, last field in the lowest bits
   typedef struct packed {
      logic             jump_taken;
      logic             carry_flag;
      logic [NIB_W-1:0] reg_b_value;
      logic [NIB_W-1:0] reg_a_value;
      logic [NIB_W-1:0] next_pc;
      logic             out_written;
      logic [NIB_W-1:0] out_value;
   } rsp_fields_type;

   localparam int RSP_FIELDS_W = $bits(rsp_fields_type);
   localparam int RSP_PAD_W    = RSP_DATA_W - RSP_FIELDS_W;

endpackage

@@ design/tfbc_imem.sv @@
// Instruction memory with a registered fetch port and write-to-read bypass.
module tfbc_imem #(
   parameter int MEM_DEPTH = tfbc_pkg::MEM_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  tfbc_pkg::mem_wr_type          mem_wr,
   input  logic [$clog2(MEM_DEPTH)-1:0]  rd_addr,
   output logic [tfbc_pkg::WORD_W-1:0]   fetch_word
);
   import tfbc_pkg::*;

   localparam int PC_W  = $clog2(MEM_DEPTH);
   localparam int EXT_W = PC_W + ADDR_W + 1;

   logic [WORD_W-1:0] mem_ff [MEM_DEPTH];
   logic [WORD_W-1:0] fetch_word_ff;
   logic [WORD_W-1:0] fetch_word_in;
   logic [EXT_W-1:0]  wr_ext;
   logic [PC_W-1:0]   wr_idx;
   logic              wr_hit;

   // Loads beyond the memory are dropped
   assign wr_ext = EXT_W'(mem_wr.addr);
   assign wr_idx = wr_ext[PC_W-1:0];
   assign wr_hit = mem_wr.en && (wr_ext < EXT_W'(MEM_DEPTH));

   // A load to the entry being fetched shows up at once
   assign fetch_word_in = (wr_hit && (wr_idx == rd_addr)) ? mem_wr.word : mem_ff[rd_addr];

   always_ff @(posedge clock) begin
      if (wr_hit) begin
         mem_ff[wr_idx] <= mem_wr.word;
      end
      fetch_word_ff <= fetch_word_in;
   end

   assign fetch_word = fetch_word_ff;

endmodule

@@ design/tfbc_exec.sv @@
// Decode, ALU, register file and program counter of the core.
`include "assert_macros.svh"
module tfbc_exec #(
   parameter int MEM_DEPTH = tfbc_pkg::MEM_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step_fire,
   input  logic [tfbc_pkg::WORD_W-1:0]   fetch_word,
   output logic [$clog2(MEM_DEPTH)-1:0]  rd_addr,
   output tfbc_pkg::rsp_fields_type      result
);
   import tfbc_pkg::*;

   localparam int PC_W = $clog2(MEM_DEPTH);

   logic [PC_W-1:0]  pc_ff, pc_in;
   logic [NIB_W-1:0] a_ff, a_in;
   logic [NIB_W-1:0] b_ff, b_in;
   logic [NIB_W-1:0] out_ff, out_in;

   logic             jmp, jcar, simm, sub, carry, jump, written;
   dest_type         dest;
   logic [IMM_W-1:0] imm;
   logic [NIB_W:0]   alu_full;
   logic [NIB_W-1:0] sel;
   logic [PC_W-1:0]  pc_seq, imm_pc;
   logic [PC_W+NIB_W-1:0] pc_ext;

   // Instruction fields
   assign jmp  = fetch_word[7];
   assign jcar = fetch_word[6];
   assign dest = dest_type'(fetch_word[5:4]);
   assign simm = fetch_word[3];
   assign sub  = fetch_word[2];
   assign imm  = fetch_word[IMM_W-1:0];

   // Add or subtract; bit 4 is the carry or borrow
   assign alu_full = sub ? ({1'b0, a_ff} - {1'b0, b_ff}) : ({1'b0, a_ff} + {1'b0, b_ff});
   assign carry    = alu_full[NIB_W];
   assign sel      = simm ? NIB_W'(imm) : alu_full[NIB_W-1:0];

   // Destination write
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      out_in  = out_ff;
      written = 1'b0;
      unique case (dest)
         DEST_A:    a_in = sel;
         DEST_B:    b_in = sel;
         DEST_OUT: begin
            out_in  = a_ff;
            written = 1'b1;
         end
         DEST_NONE: ;
         default:   ;
      endcase
   end

   // Program counter: jump target or wrap-around increment
   assign jump   = jmp || (jcar && carry);
   assign imm_pc = PC_W'(imm);
   assign pc_seq = (pc_ff == PC_W'(MEM_DEPTH - 1)) ? '0 : pc_ff + PC_W'(1);
   assign pc_in  = jump ? imm_pc : pc_seq;

   // Prefetch the word of the next step; reset points the fetch at entry zero
   assign rd_addr = reset ? '0 : (step_fire ? pc_in : pc_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff  <= '0;
         a_ff   <= '0;
         b_ff   <= '0;
         out_ff <= '0;
      end else if (step_fire) begin
         pc_ff  <= pc_in;
         a_ff   <= a_in;
         b_ff   <= b_in;
         out_ff <= out_in;
      end
   end

   // Machine state after this step
   assign pc_ext             = (PC_W + NIB_W)'(pc_in);
   assign result.out_value   = out_in;
   assign result.out_written = written;
   assign result.next_pc     = pc_ext[NIB_W-1:0];
   assign result.reg_a_value = a_in;
   assign result.reg_b_value = b_in;
   assign result.carry_flag  = carry;
   assign result.jump_taken  = jump;

   `TFBC_ASSERT(a_jump_loads_imm, clock, reset, (step_fire && jmp) |=> (pc_ff == $past(imm_pc)))
   `TFBC_ASSERT(a_none_keeps_regs, clock, reset, (step_fire && dest == DEST_NONE) |=> ($stable(a_ff) && $stable(b_ff) && $stable(out_ff)))
   `TFBC_ASSERT(a_idle_holds_state, clock, reset, !step_fire |=> ($stable(pc_ff) && $stable(a_ff) && $stable(b_ff)))

endmodule

@@ design/tfbc_rsp_skid.sv @@
// Two-entry output stage that decouples the result stream from the core.
`include "assert_macros.svh"
module tfbc_rsp_skid (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  tfbc_pkg::rsp_fields_type          push_data,
   output logic                              can_push,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [tfbc_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import tfbc_pkg::*;

   logic           main_valid_ff, skid_valid_ff;
   rsp_fields_type main_ff, skid_ff;
   logic           pop;

   assign pop      = main_valid_ff && rsp_tready;
   assign can_push = !skid_valid_ff;

   // Control: main entry feeds the port, skid catches a push during a stall
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (main_valid_ff && !pop) begin
            skid_valid_ff <= 1'b1;
         end else begin
            main_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         main_valid_ff <= 1'b0;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            main_ff <= skid_ff;
         end
      end else if (push) begin
         if (main_valid_ff && !pop) begin
            skid_ff <= push_data;
         end else begin
            main_ff <= push_data;
         end
      end
   end

   assign rsp_tvalid = main_valid_ff;
   assign rsp_tdata  = {RSP_PAD_W'(0), main_ff};

   `TFBC_ASSERT(a_skid_needs_main, clock, reset, skid_valid_ff |-> main_valid_ff)
   `TFBC_ASSERT(a_no_push_when_full, clock, reset, push |-> !skid_valid_ff)
   `TFBC_ASSERT_NR(a_reset_empties, clock, reset |=> (!main_valid_ff && !skid_valid_ff))

endmodule

@@ design/tiny_four_bit_cpu_core.sv @@
// Four-bit processor core: one instruction step per accepted step transaction.
// A step's result is registered into the output stage when the step is accepted.
// Throughput: one transaction per cycle while req_tready is high, loads and steps alike,
//   set by the single decode/ALU pass between registered fetch word and output stage.
// Reset (synchronous): clears PC, A, B, output register and the output stage;
//   the instruction memory keeps its contents and holds no values until loaded.
module tiny_four_bit_cpu_core #(
   parameter int MEM_DEPTH = tfbc_pkg::MEM_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [tfbc_pkg::REQ_DATA_W-1:0]   req_tdata,  // load_address[3:0], load_word[11:4]
   input  logic                              req_tuser,  // operation[0]
   // Result stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_value[3:0], out_written[4], next_pc[8:5], reg_a_value[12:9],
   // reg_b_value[16:13], carry_flag[17], jump_taken[18]
   output logic [tfbc_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import tfbc_pkg::*;

   localparam int PC_W = $clog2(MEM_DEPTH);

   logic           in_fire, step_fire;
   mem_wr_type     mem_wr;
   logic [PC_W-1:0] rd_addr;
   logic [WORD_W-1:0] fetch_word;
   rsp_fields_type result;

   // Transaction decode
   assign in_fire     = req_tvalid && req_tready;
   assign step_fire   = in_fire && (req_tuser == OP_STEP);
   assign mem_wr.en   = in_fire && (req_tuser == OP_LOAD);
   assign mem_wr.addr = req_tdata[ADDR_W-1:0];
   assign mem_wr.word = req_tdata[ADDR_W+WORD_W-1:ADDR_W];

   tfbc_imem #(
      .MEM_DEPTH(MEM_DEPTH)
   ) u_imem (
      .clock     (clock),
      .mem_wr    (mem_wr),
      .rd_addr   (rd_addr),
      .fetch_word(fetch_word)
   );

   tfbc_exec #(
      .MEM_DEPTH(MEM_DEPTH)
   ) u_exec (
      .clock     (clock),
      .reset     (reset),
      .step_fire (step_fire),
      .fetch_word(fetch_word),
      .rd_addr   (rd_addr),
      .result    (result)
   );

   tfbc_rsp_skid u_rsp_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (step_fire),
      .push_data (result),
      .can_push  (req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

endmodule

@@ tb/tiny_four_bit_cpu_core_test.sv @@
// Testbench for the four-bit processor core: loads, steps, scoreboard and stream stalls.
module tiny_four_bit_cpu_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import tfbc_pkg::*;

   // Instruction word layout
   localparam int JUMP_BIT = 7;
   localparam int JCAR_BIT = 6;
   localparam int DEST_LSB = 4;
   localparam int SIMM_BIT = 3;
   localparam int SUB_BIT  = 2;

   // Run shape
   localparam int RANDOM_ITEMS = 424;
   localparam int PRESSURE_AT  = 150;
   localparam int LONG_HOLD    = 64;
   localparam int DRAIN_CYCLES = 4;
   localparam int CYCLE_LIMIT  = 100000;

   // Program loaded into every entry; the directed steps walk through it
   localparam logic [WORD_W-1:0] BOOT_PROGRAM [16] = '{
      8'h0F, 8'h1E, 8'h00, 8'h00, 8'h04, 8'h20, 8'h74, 8'h8D,
      8'hFF, 8'h3B, 8'h55, 8'hAA, 8'hC3, 8'h18, 8'h96, 8'h6E
   };
   localparam int BOOT_STEPS = 10;

   // Receiver stall patterns
   typedef enum int {RX_FREE, RX_COIN, RX_SLOW} rx_mode_type;

   // Processor state tracker and expected step reports
   class cpu_state_scoreboard;
      logic [WORD_W-1:0] imem [16];
      logic [NIB_W-1:0]  pc;
      logic [NIB_W-1:0]  reg_a;
      logic [NIB_W-1:0]  reg_b;
      logic [NIB_W-1:0]  out_reg;
      rsp_fields_type    expected_states[$];
      int                mismatches;

      function new();
         pc         = '0;
         reg_a      = '0;
         reg_b      = '0;
         out_reg    = '0;
         mismatches = 0;
      endfunction

      // Loads update memory; steps execute one instruction and queue its report
      function void apply_request(logic op, logic [ADDR_W-1:0] addr, logic [WORD_W-1:0] word);
         logic [WORD_W-1:0] instr;
         logic [NIB_W:0]    alu_full;
         logic [NIB_W-1:0]  operand;
         logic [NIB_W-1:0]  imm;
         rsp_fields_type    state;
         if (op == OP_LOAD) begin
            imem[addr] = word;
            return;
         end
         instr = imem[pc];
         imm = {1'b0, instr[IMM_W-1:0]};
         // full-width ALU; bit 4 is carry on add and borrow on subtract
         alu_full = instr[SUB_BIT] ? {1'b0, reg_a} - {1'b0, reg_b}
                                   : {1'b0, reg_a} + {1'b0, reg_b};
         operand = instr[SIMM_BIT] ? imm : alu_full[NIB_W-1:0];
         state = '0;
         case (dest_type'(instr[DEST_LSB+1:DEST_LSB]))
            DEST_A: reg_a = operand;
            DEST_B: reg_b = operand;
            DEST_OUT: begin
               out_reg = reg_a;
               state.out_written = 1'b1;
            end
            DEST_NONE: ;
         endcase
         state.carry_flag = alu_full[NIB_W];
         state.jump_taken = instr[JUMP_BIT] | (instr[JCAR_BIT] & alu_full[NIB_W]);
         pc = state.jump_taken ? imm : pc + 1'b1;
         state.out_value   = out_reg;
         state.next_pc     = pc;
         state.reg_a_value = reg_a;
         state.reg_b_value = reg_b;
         expected_states.push_back(state);
      endfunction

      task report(string msg);
         $display("ERROR: %s", msg);
         mismatches++;
      endtask

      task compare_field(string name, int got, int want);
         if (got != want)
            report($sformatf("%s: got %0d, expected %0d", name, got, want));
      endtask

      // Compare one accepted result with the oldest expected step report
      task check_state_report(rsp_fields_type got);
         rsp_fields_type want;
         if (expected_states.size() == 0) begin
            report($sformatf("result with no step pending: %h", got));
            return;
         end
         want = expected_states.pop_front();
         compare_field("out_value", int'(got.out_value), int'(want.out_value));
         compare_field("out_written", int'(got.out_written), int'(want.out_written));
         compare_field("next_pc", int'(got.next_pc), int'(want.next_pc));
         compare_field("reg_a_value", int'(got.reg_a_value), int'(want.reg_a_value));
         compare_field("reg_b_value", int'(got.reg_b_value), int'(want.reg_b_value));
         compare_field("carry_flag", int'(got.carry_flag), int'(want.carry_flag));
         compare_field("jump_taken", int'(got.jump_taken), int'(want.jump_taken));
      endtask
   endclass

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = OP_LOAD;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   bit                    hold_off_req = 1'b0;
   int                    cycle_count  = 0;
   cpu_state_scoreboard   scoreboard   = new();

   tiny_four_bit_cpu_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   // Transaction monitor on both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            scoreboard.apply_request(req_tuser, req_tdata[ADDR_W-1:0],
                                     req_tdata[ADDR_W+WORD_W-1:ADDR_W]);
         if (rsp_tvalid && rsp_tready)
            scoreboard.check_state_report(rsp_tdata[RSP_FIELDS_W-1:0]);
      end
   end

   // Receiver: changing stall patterns, plus one long hold-off on request
   initial begin
      rx_mode_type mode;
      int          mode_left;
      int          hold_left;
      mode      = RX_FREE;
      mode_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_left    = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = rx_mode_type'($urandom_range(0, 2));
               mode_left = $urandom_range(8, 60);
            end
            mode_left--;
            case (mode)
               RX_FREE: rsp_tready <= 1'b1;
               RX_COIN: rsp_tready <= ($urandom_range(0, 1) == 1);
               RX_SLOW: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Offer one transaction and hold it until accepted
   task automatic send_item(input logic op, input logic [ADDR_W-1:0] addr,
                            input logic [WORD_W-1:0] word);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(REQ_DATA_W-ADDR_W-WORD_W){1'b0}}, word, addr};
      do @(posedge clock); while (!req_tready);
   endtask

   // Stimulus
   initial begin
      int                burst_left;
      logic [WORD_W-1:0] word;
      burst_left = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: fill memory, then run through the program
      for (int i = 0; i < 16; i++)
         send_item(OP_LOAD, ADDR_W'(i), BOOT_PROGRAM[i]);
      for (int i = 0; i < BOOT_STEPS; i++)
         send_item(OP_STEP, ADDR_W'(i), ~BOOT_PROGRAM[i]);

      // random: mostly steps, with program rewrites mixed in
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == PRESSURE_AT) begin
            hold_off_req = 1'b1;
            burst_left   = 48;
         end
         if (burst_left == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            burst_left = $urandom_range(1, 30);
         end
         burst_left--;
         word = WORD_W'($urandom);
         // keep unconditional jumps rarer so the upper half of memory runs too
         if ($urandom_range(0, 3) != 0)
            word[JUMP_BIT] = 1'b0;
         if ($urandom_range(0, 3) == 0)
            send_item(OP_LOAD, ADDR_W'($urandom_range(0, 15)), word);
         else
            send_item(OP_STEP, ADDR_W'($urandom_range(0, 15)), WORD_W'($urandom));
      end
      req_tvalid <= 1'b0;

      // drain
      while (scoreboard.expected_states.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (scoreboard.expected_states.size() != 0)
         scoreboard.report("step results still outstanding at end of run");

      if (scoreboard.mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
